// File: sv/assert_macros.svh
// Shared concurrent assertion macros
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a property holds on every clock edge outside reset
`define VPSC_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// Check that a condition never holds outside reset
`define VPSC_NEVER(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) !(cond)) else $error(msg);

`endif

// File: sv/vpsc_pkg.sv
`default_nettype none

package vpsc_pkg;

  localparam int unsigned HEADER_W = 16;
  localparam int unsigned NUMBER_W = 12;
  localparam int unsigned COUNT_W  = 16;
  localparam int unsigned POS_W    = 7;
  localparam int unsigned VERDICT_W = 3;

  localparam logic [HEADER_W-1:0] DISCARD_MASK    = 16'h0F00;
  localparam logic [NUMBER_W-1:0] MAX_INDEX_RESET = 12'd60;
  localparam logic [COUNT_W-1:0]  COUNT_MAX       = 16'hFFFF;

  typedef enum logic [VERDICT_W-1:0] {
    VERDICT_IN_SEQ      = 3'd0,
    VERDICT_DISCARD     = 3'd1,
    VERDICT_BAD_NUMBER  = 3'd2,
    VERDICT_OUT_OF_SEQ  = 3'd3,
    VERDICT_REPEAT_ZERO = 3'd4,
    VERDICT_SKIPPED     = 3'd5
  } verdict_t;

  typedef enum logic [1:0] {
    CLASS_NONE    = 2'd0,
    CLASS_VALID   = 2'd1,
    CLASS_DISCARD = 2'd2
  } pkt_class_t;

  typedef struct packed {
    logic [NUMBER_W-1:0] last_number;
    logic                have_last;
    pkt_class_t          prev_class;
    logic [COUNT_W-1:0]  discard_count;
    logic [POS_W-1:0]    read_pos;
    logic                skipping;
  } seq_state_t;

  typedef struct packed {
    verdict_t verdict;
    logic     need_resync;
  } check_result_t;

endpackage

`default_nettype wire

// File: sv/vpsc_classify.sv
`default_nettype none

module vpsc_classify #(
  parameter int unsigned PACKETS_IN_READ = 120
) (
  input  wire logic [vpsc_pkg::HEADER_W-1:0] header,
  input  wire logic [vpsc_pkg::NUMBER_W-1:0] max_index,
  input  wire vpsc_pkg::seq_state_t          state_cur,
  output vpsc_pkg::seq_state_t               state_nxt,
  output vpsc_pkg::check_result_t            result
);

  localparam logic [vpsc_pkg::POS_W:0] READ_LEN = (vpsc_pkg::POS_W+1)'(PACKETS_IN_READ);

  logic [vpsc_pkg::NUMBER_W-1:0] number;
  logic [vpsc_pkg::POS_W:0]      pos_inc;
  logic                          read_end;
  logic [vpsc_pkg::POS_W-1:0]    pos_adv;
  logic                          is_discard;
  logic                          seq_ok;

  assign number     = header[vpsc_pkg::NUMBER_W-1:0];
  assign is_discard = (header & vpsc_pkg::DISCARD_MASK) == vpsc_pkg::DISCARD_MASK;
  assign pos_inc    = {1'b0, state_cur.read_pos} + {{vpsc_pkg::POS_W{1'b0}}, 1'b1};
  assign read_end   = pos_inc >= READ_LEN;
  assign pos_adv    = read_end ? '0 : pos_inc[vpsc_pkg::POS_W-1:0];

  always_comb begin
    if (!state_cur.have_last) begin
      seq_ok = number == '0;
    end else begin
      seq_ok = ({1'b0, number} == {1'b0, state_cur.last_number} + 13'd1) ||
               (number == '0 && state_cur.last_number == max_index);
    end
  end

  always_comb begin
    state_nxt          = state_cur;
    result.verdict     = vpsc_pkg::VERDICT_IN_SEQ;
    result.need_resync = 1'b0;
    if (state_cur.skipping) begin
      result.verdict     = vpsc_pkg::VERDICT_SKIPPED;
      state_nxt.read_pos = pos_adv;
      state_nxt.skipping = !read_end;
    end else if (is_discard) begin
      result.verdict = vpsc_pkg::VERDICT_DISCARD;
      if (state_cur.prev_class == vpsc_pkg::CLASS_VALID) begin
        state_nxt.have_last = 1'b0;
      end
      state_nxt.prev_class = vpsc_pkg::CLASS_DISCARD;
      if (state_cur.discard_count != vpsc_pkg::COUNT_MAX) begin
        state_nxt.discard_count = state_cur.discard_count + 16'd1;
      end
      state_nxt.read_pos = pos_adv;
    end else if (number > max_index) begin
      result.verdict     = vpsc_pkg::VERDICT_BAD_NUMBER;
      result.need_resync = 1'b1;
      state_nxt          = '0;
    end else begin
      if (state_cur.prev_class == vpsc_pkg::CLASS_DISCARD) begin
        state_nxt.discard_count = '0;
      end
      state_nxt.prev_class = vpsc_pkg::CLASS_VALID;
      if (number == '0 && state_cur.have_last && state_cur.last_number == '0) begin
        result.verdict     = vpsc_pkg::VERDICT_REPEAT_ZERO;
        state_nxt.read_pos = pos_adv;
        state_nxt.skipping = !read_end;
      end else if (seq_ok) begin
        result.verdict        = vpsc_pkg::VERDICT_IN_SEQ;
        state_nxt.last_number = number;
        state_nxt.have_last   = 1'b1;
        state_nxt.read_pos    = pos_adv;
      end else begin
        result.verdict     = vpsc_pkg::VERDICT_OUT_OF_SEQ;
        result.need_resync = 1'b1;
        state_nxt          = '0;
      end
    end
  end

endmodule

`default_nettype wire

// File: sv/video_packet_sequence_checker.sv
// Video packet sequence checker.
// Input channel: in_valid/in_ready carry one 16-bit packet header per transaction.
// Result channel: out_valid/out_ready carry one result per header: verdict,
//   packet number, resync request and the current discard run length.
// Configuration: cfg_we writes cfg_wdata into the maximum packet number
//   register at once; write only while no transaction is in flight.
// Pipeline: an accepted header is held in the input register, classified there,
//   and its result is written to the result register, which drives the result channel.
// Throughput: one header per cycle while out_ready is high, set by the single
//   input and result registers with the sequence state updated between them.
// Reset (rst_n low, synchronous): both stages empty, sequence state cleared,
//   maximum packet number back to 60.
// Stall: when out_ready is low the result register holds; the input register
//   still takes one more header, then in_ready drops until the result leaves.
`default_nettype none

module video_packet_sequence_checker #(
  parameter int unsigned PACKETS_IN_READ = 120
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 in_valid,
  output logic                                      in_ready,
  input  wire logic [vpsc_pkg::HEADER_W-1:0]        in_header,
  output logic                                      out_valid,
  input  wire logic                                 out_ready,
  output logic [vpsc_pkg::VERDICT_W-1:0]            out_verdict,
  output logic [vpsc_pkg::NUMBER_W-1:0]             out_packet_number,
  output logic                                      out_need_resync,
  output logic [vpsc_pkg::COUNT_W-1:0]              out_discard_run,
  input  wire logic                                 cfg_we,
  input  wire logic [vpsc_pkg::NUMBER_W-1:0]        cfg_wdata
);

  `include "assert_macros.svh"

  logic                               s1_valid_r;
  logic [vpsc_pkg::HEADER_W-1:0]      s1_header_r;
  logic [vpsc_pkg::NUMBER_W-1:0]      max_index_r;
  vpsc_pkg::seq_state_t               state_r;
  vpsc_pkg::seq_state_t               state_nxt;
  vpsc_pkg::check_result_t            check_res;
  logic                               out_valid_r;
  vpsc_pkg::verdict_t                 out_verdict_r;
  logic [vpsc_pkg::NUMBER_W-1:0]      out_number_r;
  logic                               out_resync_r;
  logic [vpsc_pkg::COUNT_W-1:0]       out_run_r;
  logic                               s1_fire;
  logic                               in_fire;

  assign s1_fire  = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || s1_fire;
  assign in_fire  = in_valid && in_ready;

  vpsc_classify #(
    .PACKETS_IN_READ(PACKETS_IN_READ)
  ) u_classify (
    .header   (s1_header_r),
    .max_index(max_index_r),
    .state_cur(state_r),
    .state_nxt(state_nxt),
    .result   (check_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_index_r <= vpsc_pkg::MAX_INDEX_RESET;
    end else if (cfg_we) begin
      max_index_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_header_r <= in_header;
    end
  end

  // advance sequence state once per checked header
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '0;
    end else if (s1_fire) begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      out_verdict_r <= check_res.verdict;
      out_number_r  <= s1_header_r[vpsc_pkg::NUMBER_W-1:0];
      out_resync_r  <= check_res.need_resync;
      out_run_r     <= state_nxt.discard_count;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_verdict       = out_verdict_r;
  assign out_packet_number = out_number_r;
  assign out_need_resync   = out_resync_r;
  assign out_discard_run   = out_run_r;

  `VPSC_ASSERT(a_resync_clears, clk, rst_n, s1_fire && check_res.need_resync |=> state_r == '0, "resync did not clear state")
  `VPSC_NEVER(a_count_needs_discard, clk, rst_n, state_r.discard_count != '0 && state_r.prev_class != vpsc_pkg::CLASS_DISCARD, "discard run outside discard class")
  `VPSC_NEVER(a_have_last_valid, clk, rst_n, state_r.have_last && state_r.prev_class != vpsc_pkg::CLASS_VALID, "last number kept after non-valid packet")
  `VPSC_ASSERT(a_skip_after_zero, clk, rst_n, state_r.skipping |-> state_r.have_last && state_r.last_number == '0, "skipping without repeated zero")

endmodule

`default_nettype wire

// File: tb/tb_video_packet_sequence_checker.sv
module tb_video_packet_sequence_checker;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int READ_LEN = 120;
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int RANDOM_HEADERS = 1300;

  typedef struct {
    vpsc_pkg::verdict_t            verdict;
    logic [vpsc_pkg::NUMBER_W-1:0] number;
    logic                          resync;
    logic [vpsc_pkg::COUNT_W-1:0]  run;
  } pkt_result_t;

  logic                           clk;
  logic                           rst_n;
  logic                           in_valid;
  logic                           in_ready;
  logic [vpsc_pkg::HEADER_W-1:0]  in_header;
  logic                           out_valid;
  logic                           out_ready;
  logic [vpsc_pkg::VERDICT_W-1:0] out_verdict;
  logic [vpsc_pkg::NUMBER_W-1:0]  out_packet_number;
  logic                           out_need_resync;
  logic [vpsc_pkg::COUNT_W-1:0]   out_discard_run;
  logic                           cfg_we;
  logic [vpsc_pkg::NUMBER_W-1:0]  cfg_wdata;

  logic [vpsc_pkg::NUMBER_W-1:0] mdl_max;
  logic [vpsc_pkg::NUMBER_W-1:0] mdl_last;
  logic                          mdl_have_last;
  vpsc_pkg::pkt_class_t          mdl_class;
  logic [vpsc_pkg::COUNT_W-1:0]  mdl_discards;
  int                            mdl_pos;
  logic                          mdl_skip;

  pkt_result_t pending_verdicts[$];
  int          sent_headers;
  int          error_count;
  int          cycle_count;
  int          stall_left;
  bit          idle_on;

  video_packet_sequence_checker #(
    .PACKETS_IN_READ(READ_LEN)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_header(in_header),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_verdict(out_verdict),
    .out_packet_number(out_packet_number),
    .out_need_resync(out_need_resync),
    .out_discard_run(out_discard_run),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  initial clk = 1'b0;
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_video_packet_sequence_checker: errors");
      $finish;
    end
  end

  function automatic void clear_sequence();
    mdl_last = '0;
    mdl_have_last = 1'b0;
    mdl_class = vpsc_pkg::CLASS_NONE;
    mdl_discards = '0;
    mdl_pos = 0;
    mdl_skip = 1'b0;
  endfunction

  function automatic bit advance_read();
    if (mdl_pos + 1 >= READ_LEN) begin
      mdl_pos = 0;
      mdl_skip = 1'b0;
      return 1'b1;
    end
    mdl_pos = mdl_pos + 1;
    return 1'b0;
  endfunction

  function automatic pkt_result_t classify_header(input logic [vpsc_pkg::HEADER_W-1:0] hdr);
    pkt_result_t r;
    logic [vpsc_pkg::NUMBER_W-1:0] num;
    logic ok;
    num = hdr[vpsc_pkg::NUMBER_W-1:0];
    r.number = num;
    r.resync = 1'b0;
    if (mdl_skip) begin
      r.verdict = vpsc_pkg::VERDICT_SKIPPED;
      void'(advance_read());
    end else if ((hdr & vpsc_pkg::DISCARD_MASK) == vpsc_pkg::DISCARD_MASK) begin
      r.verdict = vpsc_pkg::VERDICT_DISCARD;
      if (mdl_class == vpsc_pkg::CLASS_VALID) mdl_have_last = 1'b0;
      mdl_class = vpsc_pkg::CLASS_DISCARD;
      if (mdl_discards != vpsc_pkg::COUNT_MAX) mdl_discards = mdl_discards + 1'b1;
      void'(advance_read());
    end else if (num > mdl_max) begin
      r.verdict = vpsc_pkg::VERDICT_BAD_NUMBER;
      r.resync = 1'b1;
      clear_sequence();
    end else begin
      if (mdl_class == vpsc_pkg::CLASS_DISCARD) mdl_discards = '0;
      mdl_class = vpsc_pkg::CLASS_VALID;
      if (num == '0 && mdl_have_last && mdl_last == '0) begin
        r.verdict = vpsc_pkg::VERDICT_REPEAT_ZERO;
        if (!advance_read()) mdl_skip = 1'b1;
      end else begin
        if (!mdl_have_last) begin
          ok = (num == '0);
        end else begin
          ok = ({1'b0, num} == {1'b0, mdl_last} + 13'd1) ||
               (num == '0 && mdl_last == mdl_max);
        end
        if (ok) begin
          r.verdict = vpsc_pkg::VERDICT_IN_SEQ;
          mdl_last = num;
          mdl_have_last = 1'b1;
          void'(advance_read());
        end else begin
          r.verdict = vpsc_pkg::VERDICT_OUT_OF_SEQ;
          r.resync = 1'b1;
          clear_sequence();
        end
      end
    end
    r.run = mdl_discards;
    return r;
  endfunction

  function automatic int pick_gap();
    int r;
    if (!idle_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [vpsc_pkg::NUMBER_W-1:0] next_number();
    if (!mdl_have_last || mdl_last == mdl_max) return '0;
    return mdl_last + 1'b1;
  endfunction

  always @(posedge clk) begin : check_results
    pkt_result_t exp_res;
    if (rst_n && out_valid && out_ready) begin
      if (pending_verdicts.size() == 0) begin
        error_count++;
        $error("result transaction with nothing expected");
      end else begin
        exp_res = pending_verdicts.pop_front();
        if (out_verdict !== exp_res.verdict) begin
          error_count++;
          $error("verdict: expected %0d, got %0d", exp_res.verdict, out_verdict);
        end
        if (out_packet_number !== exp_res.number) begin
          error_count++;
          $error("packet_number: expected %0d, got %0d", exp_res.number,
                 out_packet_number);
        end
        if (out_need_resync !== exp_res.resync) begin
          error_count++;
          $error("need_resync: expected %0d, got %0d", exp_res.resync, out_need_resync);
        end
        if (out_discard_run !== exp_res.run) begin
          error_count++;
          $error("discard_run: expected %0d, got %0d", exp_res.run, out_discard_run);
        end
      end
    end
    if (stall_left > 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 99) < 20) begin
      stall_left = pick_gap();
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  task automatic send_header(input logic [vpsc_pkg::HEADER_W-1:0] hdr);
    int gap;
    pkt_result_t exp_res;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_header <= hdr;
    do @(posedge clk); while (!in_ready);
    exp_res = classify_header(hdr);
    pending_verdicts.push_back(exp_res);
    sent_headers++;
  endtask

  task automatic wait_for_results();
    in_valid <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_max_index(input logic [vpsc_pkg::NUMBER_W-1:0] value);
    wait_for_results();
    cfg_wdata <= value;
    cfg_we <= 1'b1;
    @(posedge clk);
    cfg_we <= 1'b0;
    mdl_max = value;
  endtask

  task automatic flush_skipped_read();
    while (mdl_skip) send_header(16'($urandom));
  endtask

  task automatic test_directed();
    send_header(16'h0000);
    send_header(16'hF001);
    send_header(16'h0F00);
    send_header(16'hFFFF);
    send_header(16'h0002);
    send_header(16'h003D);
    send_header(16'h003C);
    send_header(16'h0EFF);
    send_header(16'h0000);
    send_header(16'h0000);
    flush_skipped_read();
    write_max_index(12'd2);
    send_header(16'h0000);
    send_header(16'h0001);
    send_header(16'h0002);
    send_header(16'h0000);
    send_header(16'h0001);
    send_header(16'h0003);
    write_max_index(12'd0);
    send_header(16'h0000);
    send_header(16'h0001);
    send_header(16'h0000);
    send_header(16'h8000);
    flush_skipped_read();
    write_max_index(12'hFFF);
    send_header(16'h0FFF);
    send_header(16'h0EFF);
    send_header(16'h0000);
    send_header(16'h0001);
    send_header(16'h7002);
  endtask

  task automatic test_read_boundary();
    write_max_index(12'd60);
    flush_skipped_read();
    send_header(16'h0EFF);
    repeat (READ_LEN - 2) send_header({4'($urandom), 4'hF, 8'($urandom)});
    send_header(16'h0000);
    send_header(16'h0000);
    send_header(16'h0000);
    flush_skipped_read();
  endtask

  task automatic test_random_traffic();
    logic [vpsc_pkg::NUMBER_W-1:0] settings[8];
    int phase_end;
    int kind;
    int len;
    int cap;
    settings = '{12'd60, 12'd1, 12'd2, 12'd0, 12'hFFF, 12'd4094, 12'd7, 12'($urandom)};
    foreach (settings[i]) begin
      write_max_index(settings[i]);
      phase_end = sent_headers + RANDOM_HEADERS / 8;
      while (sent_headers < phase_end) begin
        if ($urandom_range(0, 9) == 0) idle_on = ($urandom_range(0, 3) != 0);
        if ($urandom_range(0, 199) == 0) wait_for_results();
        kind = $urandom_range(0, 99);
        if (kind < 60) begin
          cap = (mdl_max < 12'd75) ? 2 * int'(mdl_max) + 3 : 150;
          len = $urandom_range(1, cap);
          repeat (len) send_header({4'($urandom), next_number()});
        end else if (kind < 72) begin
          len = $urandom_range(1, 6);
          repeat (len) send_header({4'($urandom), 4'hF, 8'($urandom)});
        end else if (kind < 80) begin
          send_header({4'($urandom), 12'h000});
          send_header({4'($urandom), 12'h000});
        end else if (kind < 87 && mdl_max != 12'hFFF) begin
          send_header({4'($urandom), 12'($urandom_range(int'(mdl_max) + 1, 4095))});
        end else if (kind < 94) begin
          send_header({4'($urandom), 12'($urandom_range(0, int'(mdl_max)))});
        end else begin
          send_header(16'($urandom));
        end
      end
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_header = '0;
    out_ready = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    sent_headers = 0;
    error_count = 0;
    cycle_count = 0;
    stall_left = 0;
    idle_on = 1'b1;
    mdl_max = vpsc_pkg::MAX_INDEX_RESET;
    clear_sequence();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_read_boundary();
    test_random_traffic();
    wait_for_results();
    repeat (10) @(posedge clk);
    if (error_count == 0) begin
      $display("tb_video_packet_sequence_checker: clean");
    end else begin
      $display("tb_video_packet_sequence_checker: errors");
    end
    $finish;
  end

endmodule
